/* rtl/matrix_multiply_3x3_assert.svh */
// Assertion macros used by the matrix multiplier RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MATRIX_MULTIPLY_3X3_ASSERT_SVH
`define MATRIX_MULTIPLY_3X3_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MM3_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define MM3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mm3_pkg.sv */
package mm3_pkg;

  localparam int ELEMENT_WIDTH = 8;
  localparam int PRODUCT_WIDTH = 17;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] a_element;
    logic signed [ELEMENT_WIDTH-1:0] b_element;
  } in_t;

  typedef struct packed {
    logic signed [PRODUCT_WIDTH-1:0] product_element;
    logic                            last_element;
  } out_t;

  // Control that travels alongside each read through the pipeline.
  typedef struct packed {
    logic valid;       // a term of a dot product is in this stage
    logic first_term;  // first term of the dot product, restarts the sum
    logic last_term;   // last term of the dot product, the sum is complete
    logic last_entry;  // the dot product is the final entry of the product
  } tag_t;

endpackage

/* rtl/mm3_store.sv */
module mm3_store #(
  parameter int DIM = 3,
  localparam int Cells = DIM * DIM,
  localparam int AddrW = $clog2(Cells)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   we_i,
  input  logic [AddrW-1:0]                       waddr_i,
  input  mm3_pkg::in_t                           wdata_i,
  input  logic                                   en_i,
  input  logic [AddrW-1:0]                       a_raddr_i,
  input  logic [AddrW-1:0]                       b_raddr_i,
  input  mm3_pkg::tag_t                          tag_i,
  output logic signed [mm3_pkg::ELEMENT_WIDTH-1:0] a_rdata_o,
  output logic signed [mm3_pkg::ELEMENT_WIDTH-1:0] b_rdata_o,
  output mm3_pkg::tag_t                          tag_o
);
  import mm3_pkg::*;

  logic signed [ELEMENT_WIDTH-1:0] a_mem [Cells];
  logic signed [ELEMENT_WIDTH-1:0] b_mem [Cells];
  logic signed [ELEMENT_WIDTH-1:0] a_rdata_q;
  logic signed [ELEMENT_WIDTH-1:0] b_rdata_q;
  tag_t                            tag_q;

  // One write port per matrix, filled during the load phase.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      a_mem[waddr_i] <= wdata_i.a_element;
      b_mem[waddr_i] <= wdata_i.b_element;
    end
  end

  // Registered read ports; they hold while the pipeline is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_rdata_q <= a_mem[a_raddr_i];
      b_rdata_q <= b_mem[b_raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  assign a_rdata_o = a_rdata_q;
  assign b_rdata_o = b_rdata_q;
  assign tag_o     = tag_q;

endmodule

/* rtl/mm3_mac.sv */
module mm3_mac (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic signed [mm3_pkg::ELEMENT_WIDTH-1:0] a_i,
  input  logic signed [mm3_pkg::ELEMENT_WIDTH-1:0] b_i,
  input  mm3_pkg::tag_t                            tag_i,
  output logic                                     done_o,
  output logic                                     last_entry_o,
  output logic signed [mm3_pkg::PRODUCT_WIDTH-1:0] sum_o
);
  import mm3_pkg::*;

  localparam int MulW = 2 * ELEMENT_WIDTH;

  logic signed [MulW-1:0]          prod_q;
  tag_t                            tag_q;
  logic signed [PRODUCT_WIDTH-1:0] acc_q;
  logic signed [PRODUCT_WIDTH-1:0] acc_base;
  logic signed [PRODUCT_WIDTH-1:0] sum;

  // Multiply stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  // Accumulate stage. The sum wraps at the width of the result field.
  assign acc_base = tag_q.first_term ? '0 : acc_q;
  assign sum      = acc_base + PRODUCT_WIDTH'(prod_q);

  always_ff @(posedge clk_i) begin
    if (en_i && tag_q.valid) begin
      acc_q <= sum;
    end
  end

  assign done_o       = tag_q.valid && tag_q.last_term;
  assign last_entry_o = tag_q.last_entry;
  assign sum_o        = sum;

endmodule

/* rtl/matrix_multiply_3x3.sv */
// Path: store read registers, then the multiply register, then the output register.
// Flow: DIM*DIM load transfers, then one product entry at a time, term by term through
// the single read port of each matrix memory (one term per cycle unless output stalls).
// Default size: 9 load transfers and 27 term reads per pair.
// Reset: rst_ni clears the control state; the matrix memories keep no reset value.
`include "matrix_multiply_3x3_assert.svh"

module matrix_multiply_3x3 #(
  parameter int DIM = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mm3_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mm3_pkg::out_t out_data_o
);
  import mm3_pkg::*;

  localparam int Cells = DIM * DIM;
  localparam int AddrW = $clog2(Cells);
  localparam int IdxW  = $clog2(DIM);

  // The block is either loading matrix elements or issuing the dot product
  // terms of the current pair. The two phases never overlap.
  typedef enum logic [1:0] {
    S_LOAD  = 2'b01,
    S_ISSUE = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0] load_cnt_q, load_cnt_d;
  logic [IdxW-1:0]  r_q, r_d;
  logic [IdxW-1:0]  c_q, c_d;
  logic [IdxW-1:0]  k_q, k_d;

  logic             in_xfer;
  logic             load_done;
  logic             en;
  logic             issue;
  logic             k_last, c_last, r_last;
  logic [AddrW-1:0] a_raddr, b_raddr;
  tag_t             issue_tag;
  tag_t             rd_tag;

  logic signed [ELEMENT_WIDTH-1:0] a_rdata, b_rdata;
  logic                            mac_done;
  logic                            mac_last_entry;
  logic signed [PRODUCT_WIDTH-1:0] mac_sum;

  logic out_valid_q, out_valid_d;
  out_t out_data_q;

  // Loading takes one transfer per cycle while in the load phase.
  assign in_ready_o = (state_q == S_LOAD);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_done  = in_xfer && (load_cnt_q == AddrW'(Cells - 1));

  // The whole compute pipeline (read, multiply, accumulate, output) moves as
  // one unit, and only when the output register is empty or being drained.
  // A stall therefore freezes every stage in place and no term is lost.
  assign en    = !out_valid_q || out_ready_i;
  assign issue = (state_q == S_ISSUE) && en;

  assign k_last = (k_q == IdxW'(DIM - 1));
  assign c_last = (c_q == IdxW'(DIM - 1));
  assign r_last = (r_q == IdxW'(DIM - 1));

  // Term k of entry (r, c) reads A at row r, column k and B at row k, column c.
  assign a_raddr = AddrW'(r_q) * AddrW'(DIM) + AddrW'(k_q);
  assign b_raddr = AddrW'(k_q) * AddrW'(DIM) + AddrW'(c_q);

  always_comb begin
    issue_tag            = '0;
    issue_tag.valid      = (state_q == S_ISSUE);
    issue_tag.first_term = (k_q == '0);
    issue_tag.last_term  = k_last;
    issue_tag.last_entry = r_last && c_last;
  end

  // Sequencer. The last read of a pair happens at the same edge that returns
  // the block to the load phase, so new loads never overwrite an element that
  // is still to be read.
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (load_done) begin
            load_cnt_d = '0;
            state_d    = S_ISSUE;
          end else begin
            load_cnt_d = load_cnt_q + AddrW'(1);
          end
        end
      end
      S_ISSUE: begin
        if (issue) begin
          if (!k_last) begin
            k_d = k_q + IdxW'(1);
          end else begin
            k_d = '0;
            if (!c_last) begin
              c_d = c_q + IdxW'(1);
            end else begin
              c_d = '0;
              if (!r_last) begin
                r_d = r_q + IdxW'(1);
              end else begin
                r_d     = '0;
                state_d = S_LOAD;
              end
            end
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      load_cnt_q <= '0;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      r_q        <= r_d;
      c_q        <= c_d;
      k_q        <= k_d;
    end
  end

  mm3_store #(
    .DIM (DIM)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (in_xfer),
    .waddr_i   (load_cnt_q),
    .wdata_i   (in_data_i),
    .en_i      (en),
    .a_raddr_i (a_raddr),
    .b_raddr_i (b_raddr),
    .tag_i     (issue_tag),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata),
    .tag_o     (rd_tag)
  );

  mm3_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .a_i          (a_rdata),
    .b_i          (b_rdata),
    .tag_i        (rd_tag),
    .done_o       (mac_done),
    .last_entry_o (mac_last_entry),
    .sum_o        (mac_sum)
  );

  // Output register. When the pipeline advances, it either captures a
  // completed dot product or empties because its entry was transferred.
  assign out_valid_d = mac_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && mac_done) begin
      out_data_q.product_element <= mac_sum;
      out_data_q.last_element    <= mac_last_entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The load counter rests at zero for the whole compute phase.
  `MM3_ASSERT_NOW(a_load_cnt_idle, (state_q != S_ISSUE) || (load_cnt_q == '0),
                  "load counter not zero during compute")

  // Every pass over the product starts at entry (0, 0), term 0.
  `MM3_ASSERT_NOW(a_issue_start,
                  !$rose(state_q == S_ISSUE) || ((r_q == '0) && (c_q == '0) && (k_q == '0)),
                  "compute pass does not start at the first entry")

  // Issuing the final term of the final entry ends the compute phase.
  `MM3_ASSERT_NEXT(a_issue_end, issue && issue_tag.last_entry && k_last,
                   state_q == S_LOAD, "compute phase did not end after the final term")

  // A completed dot product is never dropped while the output is stalled.
  `MM3_ASSERT_NEXT(a_hold_done, !en && mac_done, mac_done && out_valid_q,
                   "completed entry lost during an output stall")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mm3_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 10;
  localparam int TOTAL_LOADS = 279;      // 31 complete matrix pairs
  localparam int HOLD_OFF_CYCLES = 80;   // long receiver stall that backs up the block
  localparam int DRAIN_CYCLES = 20;      // quiet time after the last product to show any stray output
  localparam int STALL_LIMIT = 1000;     // cycles without any transfer before giving up

  // Element styles for a random matrix pair.
  typedef enum int {
    STYLE_FULL,
    STYLE_EXTREME,
    STYLE_SMALL
  } elem_style_e;

  // Predicts the product entries of each loaded matrix pair and checks the
  // entries that leave the block against them in order.
  class product_scoreboard;
    localparam int DIM = 3;
    localparam int CELLS = DIM * DIM;

    logic signed [ELEMENT_WIDTH-1:0] a_mat [CELLS];
    logic signed [ELEMENT_WIDTH-1:0] b_mat [CELLS];
    int unsigned fill_pos;
    out_t        product_q [$];
    int unsigned loaded;
    int unsigned checked;
    int unsigned errors;

    function new();
      fill_pos = 0;
      loaded = 0;
      checked = 0;
      errors = 0;
    endfunction

    function int pending();
      return product_q.size();
    endfunction

    task report_mismatch(string what);
      if (errors < 50) $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task note_load(in_t item);
      int   acc;
      out_t entry;
      a_mat[fill_pos] = item.a_element;
      b_mat[fill_pos] = item.b_element;
      loaded++;
      if (fill_pos != CELLS - 1) begin
        fill_pos++;
      end else begin
        fill_pos = 0;
        for (int r = 0; r < DIM; r++) begin
          for (int c = 0; c < DIM; c++) begin
            acc = 0;
            for (int k = 0; k < DIM; k++) begin
              acc += int'(a_mat[r * DIM + k]) * int'(b_mat[k * DIM + c]);
            end
            entry.product_element = acc[PRODUCT_WIDTH-1:0];
            entry.last_element = (r == DIM - 1) && (c == DIM - 1);
            product_q.push_back(entry);
          end
        end
      end
    endtask

    task check_entry(out_t got);
      out_t want;
      checked++;
      if (product_q.size() == 0) begin
        report_mismatch($sformatf("product entry %0d arrived with none expected",
                                  got.product_element));
      end else begin
        want = product_q.pop_front();
        if (got.product_element !== want.product_element) begin
          report_mismatch($sformatf("entry %0d: product_element got %0d, want %0d",
                                    checked, got.product_element, want.product_element));
        end
        if (got.last_element !== want.last_element) begin
          report_mismatch($sformatf("entry %0d: last_element got %0b, want %0b",
                                    checked, got.last_element, want.last_element));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  in_t  in_data;
  logic out_valid_o;
  logic out_ready;
  out_t out_data_o;

  product_scoreboard sb;

  // Shared between the sender and the receiver. idle_on selects whether both
  // sides insert random gaps; it is redrawn per matrix pair so that some pairs
  // run at full rate. hold_off_req asks the receiver for one long stall.
  bit idle_on;
  bit hold_off_req;
  int unsigned stall_count;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  matrix_multiply_3x3 u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // Transfer monitor. Every signal is sampled at the rising edge, before the
  // block's own updates for that edge land, so the values seen here are the
  // ones the block used to decide each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_load(in_data);
      if (out_valid_o && out_ready) sb.check_entry(out_data_o);
    end
  end

  // Watchdog: a correct block never goes this long without moving anything in
  // either direction, even through the long receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_count <= 0;
      end else begin
        stall_count <= stall_count + 1;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d entries still expected",
                 stall_count, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one load item. The gap before it is drawn per item; valid is only
  // lowered when there is a gap, so back-to-back items keep valid high and
  // never see two assignments to it in the same time step.
  task automatic send_load(input in_t item);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_pair_elems(input logic signed [7:0] a_val,
                                 input logic signed [7:0] b_val);
    in_t item;
    item.a_element = a_val;
    item.b_element = b_val;
    send_load(item);
  endtask

  // Lowers valid and waits until every predicted product entry has left the
  // block. The do-while guarantees at least one edge before valid can rise
  // again, and lets the monitor catch up on the load just accepted.
  task automatic drain_products();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic signed [ELEMENT_WIDTH-1:0] pick_element(elem_style_e style);
    logic signed [ELEMENT_WIDTH-1:0] val;
    val = ELEMENT_WIDTH'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 8) begin
      case (style)
        STYLE_EXTREME: begin
          case ($urandom_range(0, 4))
            0: val = -8'sd128;
            1: val = 8'sd127;
            2: val = -8'sd1;
            3: val = 8'sd0;
            default: val = 8'sd1;
          endcase
        end
        STYLE_SMALL: begin
          val = ELEMENT_WIDTH'($urandom_range(0, 8)) - 8'sd4;
        end
        default: begin
        end
      endcase
    end
    return val;
  endfunction

  // Receiver. It draws a stall before each product entry, or none when idling
  // is off, and serves one long hold-off when the sender asks for it. The long
  // stall is counted here so the sender keeps offering loads meanwhile and the
  // block has to back up into its load port.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Reset, stimulus and end of run.
  initial begin
    elem_style_e style;
    int unsigned n;
    sb = new();
    idle_on = 1'b0;
    hold_off_req = 1'b0;
    stall_count = 0;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The first pair drives every dot product to the positive
    // end of the result range, the second to the negative end. Both run with
    // no idling. A few mixed corner elements then open the third pair, which
    // the random part completes.
    for (int i = 0; i < 9; i++) send_pair_elems(-8'sd128, -8'sd128);
    for (int i = 0; i < 9; i++) send_pair_elems(-8'sd128, 8'sd127);
    idle_on = 1'b1;
    send_pair_elems(8'sd127, 8'sd127);
    send_pair_elems(8'sd0, -8'sd1);
    send_pair_elems(8'sd1, 8'sd0);
    send_pair_elems(-8'sd1, 8'sd1);
    send_pair_elems(8'sd127, -8'sd128);
    send_pair_elems(-8'sd128, 8'sd127);
    n = 24;

    // Random part: well-formed matrix pairs with random content. Style and
    // idling are redrawn at each pair boundary.
    style = STYLE_FULL;
    while (n < TOTAL_LOADS) begin
      if (n % 9 == 0) begin
        case ($urandom_range(0, 3))
          0: style = STYLE_EXTREME;
          1: style = STYLE_SMALL;
          default: style = STYLE_FULL;
        endcase
        idle_on = ($urandom_range(0, 3) != 0);
        if (n / 9 == 10) hold_off_req = 1'b1;
        if (n / 9 == 20) drain_products();
      end
      send_pair_elems(pick_element(style), pick_element(style));
      n++;
    end
    in_valid <= 1'b0;

    // Wait for the last products, then give the block time to show anything
    // it should not produce.
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered: %0d load transfers, %0d product entries checked over %0d products.",
             sb.loaded, sb.checked, sb.checked / 9);
    $display("Stimulus: range extremes, random gaps, long output stall, drain pause; %0d errors.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
